FILE: sv/vision_frame_checker_unit_macros.svh
// ----------------------------------------------------------------------------
// vision_frame_checker_unit_macros
// Assertion macros shared by the frame checker RTL.
// ----------------------------------------------------------------------------
`ifndef VISION_FRAME_CHECKER_UNIT_MACROS_SVH
`define VISION_FRAME_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define VFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define VFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Constants and types for the camera frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

   localparam logic [7:0] FRAME_HEADER = 8'hA5;
   localparam logic [3:0] MODE_MASK    = 4'hF;
   localparam int         FOUND_BIT    = 4;
   localparam logic [2:0] FRAME_LEN    = 3'd5;
   localparam logic [2:0] COUNT_MAX    = 3'd6;
   localparam int         NUM_BYTES    = 5;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_FRAME = 2'd1,
      STATUS_BAD_SUM   = 2'd2
   } status_type;

endpackage

`default_nettype wire

FILE: sv/vision_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// vision_frame_checker_unit
// Checks camera frames byte by byte and holds the latest target report.
// Input channel req_*: one received byte per transaction, req_frame_end
// marks the last byte of a frame. Result channel rsp_*: one transaction per
// frame end, carrying the held target flag, errors and a frame status.
// csr_we/csr_wdata write the expected vision mode; write only when idle.
// A byte is registered on acceptance and processed from that input register.
// rsp_valid is registered: the last byte of a frame passes through the input
// register and then sets the result registers.
// Throughput is one byte per cycle; a frame-end byte waits in the input
// register only while an earlier result is still stalled in rsp_*.
// A byte that is not a frame end never waits in the input register.
// Synchronous reset clears the byte count, stored bytes, held results
// and the mode register; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vision_frame_checker_unit_macros.svh"

module vision_frame_checker_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   req_frame_end,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic                   rsp_target_seen,
   output      logic signed [8:0]      rsp_error_x,
   output      logic signed [8:0]      rsp_error_y,
   output      logic [1:0]             rsp_frame_status,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_wdata
);

   import vfc_pkg::*;

   logic [1:0] mode_ff;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_end_ff;
   logic [2:0] count_ff, count_in;
   logic [7:0] bytes_ff [NUM_BYTES];
   logic       found_ff, found_in;
   logic [8:0] err_x_ff, err_x_in;
   logic [8:0] err_y_ff, err_y_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;

   logic       out_free;
   logic       s1_move;
   logic       s1_take;
   logic [7:0] b0, b1, b2, b3, b4;
   logic [2:0] len;
   logic [7:0] sum;
   logic       frame_ok;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && (!s1_end_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign s1_take   = req_valid && !req_stall;

   // view of the frame including the byte now being processed
   always_comb begin
      len = (count_ff < COUNT_MAX) ? count_ff + 3'd1 : count_ff;
      b0  = (count_ff == 3'd0) ? s1_byte_ff : bytes_ff[0];
      b1  = (count_ff == 3'd1) ? s1_byte_ff : bytes_ff[1];
      b2  = (count_ff == 3'd2) ? s1_byte_ff : bytes_ff[2];
      b3  = (count_ff == 3'd3) ? s1_byte_ff : bytes_ff[3];
      b4  = (count_ff == 3'd4) ? s1_byte_ff : bytes_ff[4];
      sum = b1 + b2 + b3;
      frame_ok = (b0 == FRAME_HEADER) && (len == FRAME_LEN) &&
                 ((b1[3:0] & MODE_MASK) == {2'b00, mode_ff});
   end

   always_comb begin
      s1_valid_in  = s1_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      count_in     = count_ff;
      found_in     = found_ff;
      err_x_in     = err_x_ff;
      err_y_in     = err_y_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_move) begin
         count_in = len;
         if (s1_end_ff) begin
            count_in     = 3'd0;
            rsp_valid_in = 1'b1;
            if (!frame_ok) begin
               found_in  = 1'b0;
               err_x_in  = 9'd0;
               err_y_in  = 9'd0;
               status_in = STATUS_BAD_FRAME;
            end else if (sum != b4) begin
               status_in = STATUS_BAD_SUM;
            end else begin
               found_in  = b1[FOUND_BIT];
               err_x_in  = b1[FOUND_BIT] ? 9'd0 - {1'b0, b2} : 9'd0;
               err_y_in  = b1[FOUND_BIT] ? 9'd0 - {1'b0, b3} : 9'd0;
               status_in = STATUS_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 2'd0;
         s1_valid_ff  <= 1'b0;
         count_ff     <= 3'd0;
         found_ff     <= 1'b0;
         err_x_ff     <= 9'd0;
         err_y_ff     <= 9'd0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_OK;
         for (int i = 0; i < NUM_BYTES; i++) begin
            bytes_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         err_x_ff     <= err_x_in;
         err_y_ff     <= err_y_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         if (s1_move && count_ff < FRAME_LEN) begin
            bytes_ff[count_ff] <= s1_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_byte_ff <= req_rx_byte;
         s1_end_ff  <= req_frame_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_seen  = found_ff;
   assign rsp_error_x      = err_x_ff;
   assign rsp_error_y      = err_y_ff;
   assign rsp_frame_status = status_ff;

   `VFC_ASSERT_NOW(a_count_sat, clock, reset, 1'b1, count_ff <= COUNT_MAX, "byte count above limit")
   `VFC_ASSERT_NOW(a_clear_on_bad, clock, reset, rsp_valid_ff && status_ff == STATUS_BAD_FRAME, !found_ff && err_x_ff == 9'd0 && err_y_ff == 9'd0, "bad frame did not clear results")
   `VFC_ASSERT_NOW(a_no_target_zero, clock, reset, !found_ff, err_x_ff == 9'd0 && err_y_ff == 9'd0, "errors set without target")
   `VFC_ASSERT_NEXT(a_count_restart, clock, reset, s1_move && s1_end_ff, count_ff == 3'd0 && rsp_valid_ff, "frame end did not restart count")
   `VFC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, s1_valid_ff && s1_end_ff && rsp_valid_ff, "input stalled without pending result")

endmodule

`default_nettype wire
